// ----- sv/cra_pkg.sv -----
// shared types and constants for the calendar rule alarm table
// used by cra_rule_mem, cra_match and calendar_rule_alarm_table; no dependencies
package cra_pkg;

   localparam int MAX_RULES = 16;
   localparam int IDX_W     = $clog2(MAX_RULES);
   localparam int CNT_W     = IDX_W + 1;

   localparam logic [1:0] KIND_WEEKLY = 2'd0;
   localparam logic [1:0] KIND_DATE   = 2'd1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // one stored rule, 50 bits
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [1:0]  kind;
      logic [7:0]  mask;
      logic [7:0]  amount;
   } rule_type;

   // current time carried by a tick
   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [2:0]  weekday;
   } tick_type;

   // compare result for one entry
   typedef struct packed {
      logic hit;
      logic weekly;
   } match_type;

endpackage

// ----- sv/calendar_rule_alarm_table.sv -----
// top level of the calendar rule alarm table: sequencer, status bits, output register
// depends on cra_pkg, cra_rule_mem, cra_match
//
// channel  dir  beat contents
// req_     in   tuser = cmd; tdata = entry_index, hour, minute, day, month, year,
//               period_kind, weekday_mask, weekday, amount
// rsp_     out  tdata = fired_index, fired_amount; tlast = last
// csr_     in   rule_count write
//
// a load writes its entry while the sequencer stays idle; a tick walks the first rule_count
// entries, at most 16, in turn through the single compare unit, then a flush step that hands off
// the final result if any; with rule_count zero a tick ends in its accept cycle
// the walk stops on an entry while a second firing waits on a full output register,
// and the flush cycle repeats while the output register is full
// reset clears the sequencer, output valid and all status bits to armed; stored
// rules are undefined until loaded
// req_tready is high only while the sequencer is idle
module calendar_rule_alarm_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] entry_index, [8:4] hour, [14:9] minute, [19:15] day, [23:20] month,
   // [35:24] year, [37:36] period_kind, [45:38] weekday_mask, [48:46] weekday,
   // [56:49] amount, rest zero
   input  logic [63:0] req_tdata,
   // [0] cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] fired_index, [11:4] fired_amount, rest zero
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [4:0]  csr_wdata
);

   localparam int IDX_W = cra_pkg::IDX_W;
   localparam int CNT_W = cra_pkg::CNT_W;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [4:0]                   count_ff;
   logic [CNT_W-1:0]             limit;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [cra_pkg::MAX_RULES-1:0] status_ff, status_in;
   cra_pkg::tick_type            tick_ff, tick_in;

   logic             pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0] pend_index_ff, pend_index_in;
   logic [7:0]       pend_amount_ff, pend_amount_in;

   logic             out_valid_ff, out_valid_in;
   logic [3:0]       out_index_ff, out_index_in;
   logic [7:0]       out_amount_ff, out_amount_in;
   logic             out_last_ff, out_last_in;

   // request fields
   logic [3:0]        f_entry_index;
   cra_pkg::rule_type load_rule;
   cra_pkg::tick_type load_tick;
   logic              load_ok;

   logic              mem_we;
   logic [IDX_W-1:0]  rd_addr;
   cra_pkg::rule_type rd_rule;
   cra_pkg::match_type match;

   logic out_free;
   logic fire;
   logic stall;
   logic last_entry;

   assign f_entry_index      = req_tdata[3:0];
   assign load_rule.hour     = req_tdata[8:4];
   assign load_rule.minute   = req_tdata[14:9];
   assign load_rule.day      = req_tdata[19:15];
   assign load_rule.month    = req_tdata[23:20];
   assign load_rule.year     = req_tdata[35:24];
   assign load_rule.kind     = req_tdata[37:36];
   assign load_rule.mask     = req_tdata[45:38];
   assign load_rule.amount   = req_tdata[56:49];
   assign load_tick.hour     = req_tdata[8:4];
   assign load_tick.minute   = req_tdata[14:9];
   assign load_tick.day      = req_tdata[19:15];
   assign load_tick.month    = req_tdata[23:20];
   assign load_tick.year     = req_tdata[35:24];
   assign load_tick.weekday  = req_tdata[48:46];

   assign load_ok = (32'(f_entry_index) < cra_pkg::MAX_RULES);

   assign limit = (32'(count_ff) > cra_pkg::MAX_RULES) ? CNT_W'(cra_pkg::MAX_RULES)
                                                        : CNT_W'(count_ff);

   cra_rule_mem u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (IDX_W'(f_entry_index)),
      .wr_data (load_rule),
      .rd_addr (rd_addr),
      .rd_data (rd_rule)
   );

   cra_match u_match (
      .rule   (rd_rule),
      .now    (tick_ff),
      .result (match)
   );

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = match.hit && !status_ff[idx_ff];
   assign stall      = fire && pend_valid_ff && !out_free;
   assign last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == limit);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      tick_in        = tick_ff;
      pend_valid_in  = pend_valid_ff;
      pend_index_in  = pend_index_ff;
      pend_amount_in = pend_amount_ff;
      out_valid_in   = out_valid_ff;
      out_index_in   = out_index_ff;
      out_amount_in  = out_amount_ff;
      out_last_in    = out_last_ff;
      mem_we         = 1'b0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == cra_pkg::CMD_LOAD) begin
                  if (load_ok) begin
                     mem_we                    = 1'b1;
                     status_in[IDX_W'(f_entry_index)] = 1'b0;
                  end
               end else begin
                  tick_in = load_tick;
                  idx_in  = '0;
                  if (limit != '0) begin
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (!stall) begin
               if (fire) begin
                  status_in[idx_ff] = 1'b1;
                  // a later firing proves the pending one is not the last
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_index_in  = 4'(pend_index_ff);
                     out_amount_in = pend_amount_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_index_in  = idx_ff;
                  pend_amount_in = rd_rule.amount;
               end else if (!match.hit && status_ff[idx_ff] && match.weekly) begin
                  status_in[idx_ff] = 1'b0;
               end
               if (last_entry) begin
                  state_in = ST_FLUSH;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_index_in  = 4'(pend_index_ff);
               out_amount_in = pend_amount_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // registered read lines up with the entry checked next cycle
      rd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         status_ff     <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         status_ff     <= status_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
         if (csr_we) begin
            count_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      tick_ff        <= tick_in;
      pend_index_ff  <= pend_index_in;
      pend_amount_ff <= pend_amount_in;
      out_index_ff   <= out_index_in;
      out_amount_ff  <= out_amount_in;
      out_last_ff    <= out_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0, out_amount_ff, out_index_ff};
   assign rsp_tlast  = out_last_ff;

   // nothing may still be pending once the sequencer is back to idle
   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("pending result left over in idle");

   // a stalled entry must not touch the status bits
   a_stall_holds_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && stall) |=> $stable(status_ff))
      else $error("status changed during a stall");

   // a result with last set is only produced when leaving the flush step
   a_last_from_flush: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff && !$stable(out_last_ff)) |-> $past(state_ff == ST_FLUSH))
      else $error("last marker set outside flush");

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff) && (!stall || pend_valid_ff))
      else $error("sequencer state or stall inconsistent");

endmodule

// ----- sv/cra_rule_mem.sv -----
// rule storage: one write port, one registered read port
// depends on cra_pkg
module cra_rule_mem (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [cra_pkg::IDX_W-1:0] wr_addr,
   input  cra_pkg::rule_type         wr_data,
   input  logic [cra_pkg::IDX_W-1:0] rd_addr,
   output cra_pkg::rule_type         rd_data
);

   cra_pkg::rule_type mem [cra_pkg::MAX_RULES];
   cra_pkg::rule_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cra_match.sv -----
// shared compare unit: checks one stored rule against the current time
// depends on cra_pkg
module cra_match (
   input  cra_pkg::rule_type  rule,
   input  cra_pkg::tick_type  now,
   output cra_pkg::match_type result
);

   logic time_eq;
   logic date_eq;
   logic day_bit;

   assign time_eq = (rule.hour == now.hour) && (rule.minute == now.minute);
   assign date_eq = (rule.day == now.day) && (rule.month == now.month)
                    && (rule.year == now.year);
   assign day_bit = rule.mask[now.weekday];

   always_comb begin
      result.weekly = (rule.kind == cra_pkg::KIND_WEEKLY);
      result.hit    = 1'b0;
      if (time_eq) begin
         if (rule.kind == cra_pkg::KIND_WEEKLY) begin
            result.hit = day_bit;
         end else if (rule.kind == cra_pkg::KIND_DATE) begin
            result.hit = date_eq;
         end
      end
   end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// self-checking testbench for calendar_rule_alarm_table: loads rules, sends time ticks and
// checks every firing beat against a table predictor kept in the testbench
// depends on cra_pkg and the calendar_rule_alarm_table rtl
module testbench;

   localparam logic [1:0] KIND_NEVER     = 2'd2;
   localparam logic [1:0] KIND_NEVER_ALT = 2'd3;
   localparam int         STALL_LIMIT    = 2000;
   localparam int         SETTLE_CYCLES  = 40;

   typedef struct {
      logic        cmd;
      logic [3:0]  entry_index;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [1:0]  period_kind;
      logic [7:0]  weekday_mask;
      logic [2:0]  weekday;
      logic [7:0]  amount;
   } alarm_req_type;

   typedef struct {
      logic [3:0] index;
      logic [7:0] amount;
      logic       last;
   } firing_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [4:0]  csr_wdata = '0;

   // predictor state
   cra_pkg::rule_type alarm_rules [cra_pkg::MAX_RULES];
   logic              rule_executed [cra_pkg::MAX_RULES];
   logic [4:0]        checked_count = '0;
   firing_type        expected_firings[$];

   // stimulus side: pending beats and the rules as the generator has planned them
   alarm_req_type     pending_reqs[$];
   cra_pkg::rule_type planned_rules [cra_pkg::MAX_RULES];
   int                source_idle_pct = 0;
   int                sink_idle_pct = 0;

   // driver, sink and watchdog state kept across clock edges
   alarm_req_type cur_req;
   int            gap_left = 0;
   int            stall_left = 0;
   int            quiet_cycles = 0;

   int phase_counts [8] = '{31, 5, 1, 0, 12, 17, 9, 16};
   int src_pcts [8] = '{10, 30, 0, 20, 10, 0, 30, 0};
   int sink_pcts [8] = '{30, 10, 20, 0, 30, 10, 0, 0};

   int failures = 0;
   int loads_seen = 0;
   int ticks_seen = 0;
   int firings_seen = 0;
   int settings_used = 0;

   calendar_rule_alarm_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < cra_pkg::MAX_RULES; i++) begin
         rule_executed[i] = 1'b0;
      end
   end

   // advance the rule table by one accepted beat and queue the firings it causes
   task automatic apply_to_table(alarm_req_type r);
      int                lim;
      int                fired;
      logic              hit;
      cra_pkg::rule_type e;
      firing_type        f;
      lim = (int'(checked_count) > cra_pkg::MAX_RULES) ? cra_pkg::MAX_RULES
                                                       : int'(checked_count);
      fired = 0;
      if (r.cmd == cra_pkg::CMD_LOAD) begin
         e.hour   = r.hour;
         e.minute = r.minute;
         e.day    = r.day;
         e.month  = r.month;
         e.year   = r.year;
         e.kind   = r.period_kind;
         e.mask   = r.weekday_mask;
         e.amount = r.amount;
         alarm_rules[r.entry_index] = e;
         rule_executed[r.entry_index] = 1'b0;
         loads_seen++;
      end else begin
         ticks_seen++;
         for (int i = 0; i < lim; i++) begin
            e = alarm_rules[i];
            hit = 1'b0;
            if (e.hour == r.hour && e.minute == r.minute) begin
               if (e.kind == cra_pkg::KIND_WEEKLY) begin
                  hit = e.mask[r.weekday];
               end else if (e.kind == cra_pkg::KIND_DATE) begin
                  hit = (e.day == r.day) && (e.month == r.month) && (e.year == r.year);
               end
            end
            if (hit) begin
               if (!rule_executed[i]) begin
                  rule_executed[i] = 1'b1;
                  f.index  = i[3:0];
                  f.amount = e.amount;
                  f.last   = 1'b0;
                  expected_firings.push_back(f);
                  fired++;
               end
            end else if (rule_executed[i] && e.kind == cra_pkg::KIND_WEEKLY) begin
               // weekly rule is armed again once its minute has passed
               rule_executed[i] = 1'b0;
            end
         end
         if (fired > 0) begin
            expected_firings[expected_firings.size() - 1].last = 1'b1;
         end
      end
   endtask

   // driver
   always @(posedge clock) begin
      automatic logic next_valid;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            apply_to_table(cur_req);
         end
         if (!req_tvalid || req_tready) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (source_idle_pct > 0 && $urandom_range(0, 99) < source_idle_pct) begin
               gap_left = $urandom_range(1, 12) - 1;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               next_valid = 1'b1;
            end
            req_tvalid <= next_valid;
            if (next_valid) begin
               req_tuser <= cur_req.cmd;
               req_tdata <= {7'b0, cur_req.amount, cur_req.weekday, cur_req.weekday_mask,
                             cur_req.period_kind, cur_req.year, cur_req.month, cur_req.day,
                             cur_req.minute, cur_req.hour, cur_req.entry_index};
            end
         end
      end
   end

   // monitor and result sink
   always @(posedge clock) begin
      automatic logic       next_ready;
      automatic firing_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            firings_seen++;
            if (expected_firings.size() == 0) begin
               $error("unexpected firing beat: index %0d amount %0d", rsp_tdata[3:0],
                      rsp_tdata[11:4]);
               failures++;
            end else begin
               want = expected_firings.pop_front();
               if (rsp_tdata[3:0] !== want.index) begin
                  $error("fired_index: expected %0d, got %0d", want.index, rsp_tdata[3:0]);
                  failures++;
               end
               if (rsp_tdata[11:4] !== want.amount) begin
                  $error("fired_amount: expected %0d, got %0d", want.amount, rsp_tdata[11:4]);
                  failures++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_tlast);
                  failures++;
               end
            end
         end
         next_ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            stall_left = $urandom_range(1, 12) - 1;
            next_ready = 1'b0;
         end
         rsp_tready <= next_ready;
      end
   end

   // watchdog on cycles with no beat and no register write
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat for %0d cycles, %0d firings outstanding", quiet_cycles,
                     expected_firings.size());
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   task automatic queue_load(logic [3:0] idx, logic [4:0] hour, logic [5:0] minute,
                             logic [4:0] day, logic [3:0] month, logic [11:0] year,
                             logic [1:0] kind, logic [7:0] mask, logic [7:0] amount);
      alarm_req_type r;
      r.cmd = cra_pkg::CMD_LOAD;
      r.entry_index = idx;
      r.hour = hour;
      r.minute = minute;
      r.day = day;
      r.month = month;
      r.year = year;
      r.period_kind = kind;
      r.weekday_mask = mask;
      r.weekday = 3'($urandom_range(0, 7));
      r.amount = amount;
      planned_rules[idx] = '{hour, minute, day, month, year, kind, mask, amount};
      pending_reqs.push_back(r);
   endtask

   task automatic queue_tick(logic [4:0] hour, logic [5:0] minute, logic [4:0] day,
                             logic [3:0] month, logic [11:0] year, logic [2:0] weekday);
      alarm_req_type r;
      r.cmd = cra_pkg::CMD_TICK;
      r.entry_index = 4'($urandom_range(0, 15));
      r.hour = hour;
      r.minute = minute;
      r.day = day;
      r.month = month;
      r.year = year;
      r.period_kind = 2'($urandom_range(0, 3));
      r.weekday_mask = 8'($urandom_range(0, 255));
      r.weekday = weekday;
      r.amount = 8'($urandom_range(0, 255));
      pending_reqs.push_back(r);
   endtask

   task automatic queue_random_load();
      int         pick;
      logic [1:0] kind;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [11:0] year;
      pick = $urandom_range(0, 99);
      kind = (pick < 45) ? cra_pkg::KIND_WEEKLY : (pick < 80) ? cra_pkg::KIND_DATE :
             (pick < 90) ? KIND_NEVER : KIND_NEVER_ALT;
      // a few popular times so that several rules fire on one tick
      hour   = $urandom_range(0, 1) ? 5'($urandom_range(0, 23)) :
               ($urandom_range(0, 1) ? 5'd8 : 5'd20);
      minute = $urandom_range(0, 1) ? 6'($urandom_range(0, 59)) :
               ($urandom_range(0, 1) ? 6'd0 : 6'd45);
      year   = $urandom_range(0, 1) ? 12'($urandom_range(0, 4095)) : 12'd2000;
      queue_load(4'($urandom_range(0, 15)), hour, minute, 5'($urandom_range(1, 31)),
                 4'($urandom_range(1, 12)), year, kind, 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
   endtask

   task automatic queue_random_tick(int lim);
      int                pick;
      cra_pkg::rule_type r;
      logic [2:0]        wd;
      pick = $urandom_range(0, 99);
      if (lim > 0 && pick < 80) begin
         // aim at a live rule, sometimes one minute off so weekly rules re-arm
         r = planned_rules[$urandom_range(0, lim - 1)];
         wd = 3'($urandom_range(0, 7));
         if (r.mask != 8'h00) begin
            while (!r.mask[wd]) wd = 3'($urandom_range(0, 7));
         end
         if (pick >= 66) begin
            r.minute = (r.minute == 6'd59) ? 6'd0 : r.minute + 6'd1;
         end
         if (r.kind != cra_pkg::KIND_DATE && $urandom_range(0, 1)) begin
            r.day = 5'($urandom_range(1, 31));
            r.month = 4'($urandom_range(1, 12));
            r.year = 12'($urandom_range(0, 4095));
         end
         queue_tick(r.hour, r.minute, r.day, r.month, r.year, wd);
      end else begin
         queue_tick(5'($urandom_range(0, 23)), 6'($urandom_range(0, 59)),
                    5'($urandom_range(1, 31)), 4'($urandom_range(1, 12)),
                    12'($urandom_range(0, 4095)), 3'($urandom_range(0, 7)));
      end
   endtask

   // sender holds off until the table has answered everything and finished its walk
   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_firings.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_rule_count(logic [4:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      checked_count = value;
      settings_used++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int   lim;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // count still zero: a tick checks nothing, then every entry gets loaded
      queue_tick(5'd0, 6'd0, 5'd1, 4'd1, 12'd0, 3'd0);
      queue_load(4'd0, 5'd0, 6'd0, 5'd1, 4'd1, 12'd0, cra_pkg::KIND_WEEKLY, 8'hFF, 8'd0);
      queue_load(4'd1, 5'd23, 6'd59, 5'd31, 4'd12, 12'd4095, cra_pkg::KIND_WEEKLY, 8'h80,
                 8'd255);
      queue_load(4'd2, 5'd12, 6'd30, 5'd1, 4'd1, 12'd0, cra_pkg::KIND_DATE, 8'h00, 8'hAA);
      queue_load(4'd3, 5'd23, 6'd59, 5'd31, 4'd12, 12'd4095, cra_pkg::KIND_DATE, 8'hFF,
                 8'h55);
      queue_load(4'd4, 5'd0, 6'd0, 5'd1, 4'd1, 12'd0, KIND_NEVER, 8'hFF, 8'd4);
      queue_load(4'd5, 5'd0, 6'd0, 5'd1, 4'd1, 12'd0, KIND_NEVER_ALT, 8'hFF, 8'd5);
      for (int i = 6; i < cra_pkg::MAX_RULES; i++) begin
         queue_load(i[3:0], 5'd7, 6'd15, 5'd16, 4'd8, 12'd2048, cra_pkg::KIND_WEEKLY,
                    8'h01 << ((i - 6) % 8), 8'(i * 17));
      end
      wait_drained();

      write_rule_count(5'd16);
      queue_tick(5'd0, 6'd0, 5'd1, 4'd1, 12'd0, 3'd0);
      queue_tick(5'd0, 6'd0, 5'd1, 4'd1, 12'd0, 3'd0);        // already executed
      queue_tick(5'd0, 6'd1, 5'd1, 4'd1, 12'd0, 3'd5);        // weekly re-arm
      queue_tick(5'd0, 6'd0, 5'd1, 4'd1, 12'd0, 3'd7);
      queue_tick(5'd23, 6'd59, 5'd31, 4'd12, 12'd4095, 3'd7); // weekly and date together
      queue_tick(5'd12, 6'd30, 5'd1, 4'd1, 12'd0, 3'd2);
      queue_tick(5'd12, 6'd31, 5'd1, 4'd1, 12'd0, 3'd2);      // date rule stays executed
      queue_tick(5'd12, 6'd30, 5'd1, 4'd1, 12'd0, 3'd2);
      queue_tick(5'd7, 6'd15, 5'd16, 4'd8, 12'd2048, 3'd0);
      queue_tick(5'd7, 6'd15, 5'd16, 4'd8, 12'd2048, 3'd1);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         write_rule_count(5'(phase_counts[p]));
         lim = (phase_counts[p] > cra_pkg::MAX_RULES) ? cra_pkg::MAX_RULES : phase_counts[p];
         source_idle_pct = src_pcts[p];
         sink_idle_pct = sink_pcts[p];
         for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 99) < 30) begin
               queue_random_load();
            end else begin
               queue_random_tick(lim);
            end
         end
         wait_drained();
      end

      $display("covered %0d rule loads and %0d ticks under %0d rule count settings,",
               loads_seen, ticks_seen, settings_used);
      $display("with %0d firing beats checked", firings_seen);
      if (failures == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

// ----- files.f -----
sv/cra_pkg.sv
sv/cra_rule_mem.sv
sv/cra_match.sv
sv/calendar_rule_alarm_table.sv
test/testbench.sv
